// File: rtl/kjt_pkg.sv
package kjt_pkg;

    localparam int GROUP_SLOTS_DEF = 64;
    localparam int PORT_COUNT_DEF  = 8;
    localparam int HANDLE_BITS_DEF = 32;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_DROP   = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_MAX      = 2'd1;
    localparam logic [1:0] CFG_EXPECTED = 2'd2;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 8; b++) begin
            n = n + 4'(v[b]);
        end
        return n;
    endfunction

endpackage

// File: rtl/keyed_join_table_with_timeout.sv
// Keyed join table: insert requests (kind 0) find or claim a group slot by a
// scan of the slot table, a read and an evaluate state per slot, and give one
// result (a port out of range is dropped unscanned). Sweep requests (kind 1)
// walk the table once for timeouts, once more per group evicted to meet
// max_groups, once for the first complete group, then read the ports to emit
// handles, one result per emitted handle (or one empty result, at once if no
// port is expected). The single read port of the slot memories sets the scan;
// no request is taken while one is in progress or its results are waiting.
module keyed_join_table_with_timeout #(
    parameter int GROUP_SLOTS = kjt_pkg::GROUP_SLOTS_DEF,
    parameter int PORT_COUNT  = kjt_pkg::PORT_COUNT_DEF,
    parameter int HANDLE_BITS = kjt_pkg::HANDLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_join_key,
    input  logic [2:0]  s_port,
    input  logic [31:0] s_payload,
    input  logic [63:0] s_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [6:0]  m_expired_count,
    output logic [6:0]  m_overflow_count,
    output logic        m_took_group,
    output logic [6:0]  m_pending_count,
    output logic        m_has_message,
    output logic [2:0]  m_out_port,
    output logic [31:0] m_out_payload,
    output logic        m_last
);

    localparam int SW  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int CW  = $clog2(GROUP_SLOTS + 1);
    localparam int PW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int PAW = (GROUP_SLOTS * PORT_COUNT > 1) ? $clog2(GROUP_SLOTS * PORT_COUNT) : 1;
    localparam logic [7:0] PORT_ALL = 8'((16'd1 << PORT_COUNT) - 16'd1);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_INS_RD  = 14'b00000000000010,
        S_INS_EV  = 14'b00000000000100,
        S_INS_WR  = 14'b00000000001000,
        S_EXP_RD  = 14'b00000000010000,
        S_EXP_EV  = 14'b00000000100000,
        S_OVF_CHK = 14'b00000001000000,
        S_OVF_RD  = 14'b00000010000000,
        S_OVF_EV  = 14'b00000100000000,
        S_CMP_RD  = 14'b00001000000000,
        S_CMP_EV  = 14'b00010000000000,
        S_EM_RD   = 14'b00100000000000,
        S_EM_EV   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    function automatic logic [6:0] sat7(input int v);
        return 7'((v > 127) ? 127 : v);
    endfunction

    state_t state_reg;
    logic [63:0] timeout_reg;
    logic [6:0]  max_reg;
    logic [7:0]  expect_reg;

    logic [GROUP_SLOTS-1:0] valid_reg;
    logic [CW-1:0] pend_reg, exp_cnt_reg, ovf_cnt_reg;

    logic [63:0] key_reg, ts_reg;
    logic [2:0]  port_reg;
    logic [HANDLE_BITS-1:0] pay_reg;

    logic [SW-1:0] slot_reg, tgt_reg;
    logic          found_reg, free_reg, best_reg;
    logic [63:0]   best_time_reg, old_time_reg;
    logic [7:0]    old_pres_reg, sel_reg;
    logic [PW-1:0] p_reg;
    logic          took_reg;

    logic [1:0]  o_status_reg;
    logic        o_has_reg, o_last_reg;
    logic [2:0]  o_port_reg;
    logic [31:0] o_pay_reg;

    logic [63:0] key_mem  [GROUP_SLOTS];
    logic [63:0] time_mem [GROUP_SLOTS];
    logic [7:0]  pres_mem [GROUP_SLOTS];
    logic [HANDLE_BITS-1:0] pay_mem [GROUP_SLOTS*PORT_COUNT];

    logic [63:0] key_rd, time_rd;
    logic [7:0]  pres_rd;
    logic [HANDLE_BITS-1:0] pay_rd;

    logic [7:0]  exp_mask;
    logic [3:0]  want;
    logic        slot_last, cur_valid;
    logic        ins_we;
    logic [63:0] time_new;
    logic [7:0]  pres_new;
    logic [PAW-1:0] pay_waddr, pay_raddr;
    logic        cand;

    assign exp_mask  = expect_reg & PORT_ALL;
    assign want      = kjt_pkg::popcount8(exp_mask);
    assign slot_last = (32'(slot_reg) == GROUP_SLOTS - 1);
    assign cur_valid = valid_reg[slot_reg];
    assign ins_we    = (state_reg == S_INS_WR) && (found_reg || free_reg);
    assign time_new  = (found_reg && old_time_reg != 64'd0 && old_time_reg <= ts_reg)
                       ? old_time_reg : ts_reg;
    assign pres_new  = (found_reg ? old_pres_reg : 8'd0) | (8'd1 << port_reg);
    assign pay_waddr = PAW'(int'(tgt_reg) * PORT_COUNT + int'(port_reg));
    assign pay_raddr = PAW'(int'(tgt_reg) * PORT_COUNT + int'(p_reg));
    assign cand      = cur_valid && (!best_reg || time_rd < best_time_reg);

    always_ff @(posedge aclk) begin
        if (ins_we) begin
            key_mem[tgt_reg]    <= key_reg;
            time_mem[tgt_reg]   <= time_new;
            pres_mem[tgt_reg]   <= pres_new;
            pay_mem[pay_waddr]  <= pay_reg;
        end
        key_rd  <= key_mem[slot_reg];
        time_rd <= time_mem[slot_reg];
        pres_rd <= pres_mem[slot_reg];
        pay_rd  <= pay_mem[pay_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 64'd1000;
            max_reg     <= '0;
            expect_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kjt_pkg::CFG_TIMEOUT:  timeout_reg <= cfg_data;
                kjt_pkg::CFG_MAX:      max_reg     <= cfg_data[6:0];
                kjt_pkg::CFG_EXPECTED: expect_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            pend_reg    <= '0;
            exp_cnt_reg <= '0;
            ovf_cnt_reg <= '0;
            took_reg    <= 1'b0;
            o_last_reg  <= 1'b0;
            o_has_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        key_reg     <= s_join_key;
                        ts_reg      <= s_time_ms;
                        port_reg    <= s_port;
                        pay_reg     <= HANDLE_BITS'(s_payload);
                        exp_cnt_reg <= '0;
                        ovf_cnt_reg <= '0;
                        took_reg    <= 1'b0;
                        slot_reg    <= '0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        o_has_reg   <= 1'b0;
                        o_port_reg  <= '0;
                        o_pay_reg   <= '0;
                        o_last_reg  <= 1'b1;
                        if (s_kind == kjt_pkg::KIND_INSERT) begin
                            if (32'(s_port) >= PORT_COUNT) begin
                                o_status_reg <= kjt_pkg::ST_DROP;
                                state_reg    <= S_OUT;
                            end else begin
                                state_reg <= S_INS_RD;
                            end
                        end else begin
                            o_status_reg <= kjt_pkg::ST_SWEEP;
                            state_reg <= (exp_mask == 8'd0) ? S_OUT : S_EXP_RD;
                        end
                    end
                end
                S_INS_RD: state_reg <= S_INS_EV;
                S_INS_EV: begin
                    if (cur_valid && key_rd == key_reg) begin
                        found_reg    <= 1'b1;
                        tgt_reg      <= slot_reg;
                        old_time_reg <= time_rd;
                        old_pres_reg <= pres_rd;
                    end else if (!cur_valid && !free_reg && !found_reg) begin
                        free_reg <= 1'b1;
                        tgt_reg  <= slot_reg;
                    end
                    if (slot_last) begin
                        state_reg <= S_INS_WR;
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_WR: begin
                    if (found_reg || free_reg) begin
                        o_status_reg <= kjt_pkg::ST_ACCEPT;
                        if (!found_reg) begin
                            valid_reg[tgt_reg] <= 1'b1;
                            pend_reg <= pend_reg + 1'b1;
                        end
                    end else begin
                        o_status_reg <= kjt_pkg::ST_DROP;
                    end
                    state_reg <= S_OUT;
                end
                S_EXP_RD: state_reg <= S_EXP_EV;
                S_EXP_EV: begin
                    if (cur_valid && (time_rd + timeout_reg) < ts_reg) begin
                        valid_reg[slot_reg] <= 1'b0;
                        exp_cnt_reg <= exp_cnt_reg + 1'b1;
                        pend_reg    <= pend_reg - 1'b1;
                    end
                    if (slot_last) begin
                        state_reg <= S_OVF_CHK;
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_EXP_RD;
                    end
                end
                S_OVF_CHK: begin
                    slot_reg <= '0;
                    best_reg <= 1'b0;
                    if (max_reg != 7'd0 && 32'(pend_reg) > 32'(max_reg)) begin
                        state_reg <= S_OVF_RD;
                    end else begin
                        state_reg <= S_CMP_RD;
                    end
                end
                S_OVF_RD: state_reg <= S_OVF_EV;
                S_OVF_EV: begin
                    if (cand) begin
                        best_reg      <= 1'b1;
                        best_time_reg <= time_rd;
                        tgt_reg       <= slot_reg;
                    end
                    if (slot_last) begin
                        if (cand || best_reg) begin
                            valid_reg[cand ? slot_reg : tgt_reg] <= 1'b0;
                            ovf_cnt_reg <= ovf_cnt_reg + 1'b1;
                            pend_reg    <= pend_reg - 1'b1;
                            state_reg   <= S_OVF_CHK;
                        end else begin
                            slot_reg  <= '0;
                            state_reg <= S_CMP_RD;
                        end
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_OVF_RD;
                    end
                end
                S_CMP_RD: state_reg <= S_CMP_EV;
                S_CMP_EV: begin
                    p_reg <= '0;
                    if (cur_valid && kjt_pkg::popcount8(pres_rd) == want) begin
                        valid_reg[slot_reg] <= 1'b0;
                        pend_reg <= pend_reg - 1'b1;
                        took_reg <= 1'b1;
                        tgt_reg  <= slot_reg;
                        sel_reg  <= exp_mask & pres_rd;
                        state_reg <= ((exp_mask & pres_rd) == 8'd0) ? S_OUT : S_EM_RD;
                    end else if (slot_last) begin
                        state_reg <= S_OUT;
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_CMP_RD;
                    end
                end
                S_EM_RD: state_reg <= S_EM_EV;
                S_EM_EV: begin
                    if (sel_reg[p_reg]) begin
                        o_has_reg  <= 1'b1;
                        o_port_reg <= 3'(p_reg);
                        o_pay_reg  <= 32'(pay_rd);
                        o_last_reg <= ((sel_reg >> p_reg) >> 1) == 8'd0;
                        state_reg  <= S_OUT;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_EM_RD;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (o_last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_OUT);
    assign m_status         = o_status_reg;
    assign m_expired_count  = sat7(int'(exp_cnt_reg));
    assign m_overflow_count = sat7(int'(ovf_cnt_reg));
    assign m_took_group     = took_reg;
    assign m_pending_count  = sat7(int'(pend_reg));
    assign m_has_message    = o_has_reg;
    assign m_out_port       = o_port_reg;
    assign m_out_payload    = o_pay_reg;
    assign m_last           = o_last_reg;

endmodule

// File: rtl/kjt_checker.sv
module kjt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic       m_has_message,
    input logic       m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");

    a_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_message |-> m_status == kjt_pkg::ST_SWEEP)
        else $error("message on insert result");

    a_ins_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != kjt_pkg::ST_SWEEP |-> m_last)
        else $error("insert result not last");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_message |-> m_last)
        else $error("empty result not last");

endmodule

bind keyed_join_table_with_timeout kjt_checker u_kjt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_has_message (m_has_message),
    .m_last        (m_last)
);
